[hdl/ptt_pkg.sv]
`default_nettype none

package ptt_pkg;

    // Table size default
    localparam int NUM_TIMERS_DEF = 16;

    // Field widths
    localparam int ACT_W        = 2;
    localparam int ELAPSED_W    = 31;
    localparam int TIME_W       = 32;
    localparam int SLOT_FIELD_W = 4;
    localparam int KIND_W       = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd3;

endpackage

`default_nettype wire

[hdl/ptt_cmd_if.sv]
`default_nettype none

interface ptt_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ptt_pkg::ACT_W-1:0]           action;
    logic [ptt_pkg::ELAPSED_W-1:0]       elapsed_ms;
    logic [ptt_pkg::TIME_W-1:0]          period_ms;
    logic [ptt_pkg::TIME_W-1:0]          initial_ms;
    logic [ptt_pkg::SLOT_FIELD_W-1:0]    slot;

    modport source (output valid, output action, output elapsed_ms, output period_ms,
                    output initial_ms, output slot, input ready);
    modport sink   (input valid, input action, input elapsed_ms, input period_ms,
                    input initial_ms, input slot, output ready);
endinterface

`default_nettype wire

[hdl/ptt_evt_if.sv]
`default_nettype none

interface ptt_evt_if;
    logic                                valid;
    logic                                ready;
    logic [ptt_pkg::KIND_W-1:0]          kind;
    logic [ptt_pkg::SLOT_FIELD_W-1:0]    timer_slot;
    logic                                last;

    modport source (output valid, output kind, output timer_slot, output last, input ready);
    modport sink   (input valid, input kind, input timer_slot, input last, output ready);
endinterface

`default_nettype wire

[hdl/ptt_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module ptt_ram #(
    parameter int WIDTH = ptt_pkg::TIME_W,
    parameter int DEPTH = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/periodic_timer_table_top.sv]
`default_nettype none
// Flow: an add/cancel result passes the RESP state into the output register and on to evt;
//   a tick walks the period/remaining RAM slot by slot, then its fired words leave the sorted
//   queue through the output register, one fired word per cycle while evt is not stalled.
// Commands: one at a time; a tick holds the block for its walk and fired words (the walk is
//   bounded by the single RAM read port); evt stalls lengthen both tick and add/cancel.
// Reset (rst_n, async, active low) clears active flags, fired queue and control; RAM is kept.

module periodic_timer_table_top #(
    parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ptt_cmd_if.sink     cmd,
    ptt_evt_if.source   evt
);

    localparam int SLOT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
    localparam int TIME_W  = ptt_pkg::TIME_W;
    localparam int ENTRY_W = 2 * TIME_W;
    localparam int SF_W    = ptt_pkg::SLOT_FIELD_W;
    localparam int KIND_W  = ptt_pkg::KIND_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a command word
    localparam logic [1:0] ST_WALK = 2'd1;  // tick: read every slot, write back the active ones
    localparam logic [1:0] ST_POP  = 2'd2;  // tick: drain the sorted fired queue
    localparam logic [1:0] ST_RESP = 2'd3;  // add/cancel: hand over the single result

    logic [1:0]              state_reg, state_next;

    // Slot active flags live in flops so reset clears them at once.
    logic [NUM_TIMERS-1:0]   active_reg;

    // Tick walk bookkeeping
    logic [CNT_W-1:0]        idx_reg;
    logic                    chk_valid_reg;     // RAM data this cycle belongs to chk_idx_reg
    logic [SLOT_W-1:0]       chk_idx_reg;
    logic [ptt_pkg::ELAPSED_W-1:0] elapsed_reg;

    // Pending single result for add/cancel
    logic [KIND_W-1:0]       pend_kind_reg;
    logic [SF_W-1:0]         pend_slot_reg;

    // Output register
    logic                    out_valid_reg;
    logic [KIND_W-1:0]       out_kind_reg;
    logic [SF_W-1:0]         out_slot_reg;
    logic                    out_last_reg;

    // Fired queue: a row of cells kept sorted by remaining time before the tick.
    logic [NUM_TIMERS-1:0]   q_valid_reg, q_valid_next;
    logic [TIME_W-1:0]       q_key_reg  [NUM_TIMERS];
    logic [TIME_W-1:0]       q_key_next [NUM_TIMERS];
    logic [SLOT_W-1:0]       q_slot_reg  [NUM_TIMERS];
    logic [SLOT_W-1:0]       q_slot_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   q_gt;

    // RAM: {period, remaining} per slot
    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic                    cmd_acc;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    cancel_hit;
    logic [TIME_W-1:0]       add_rem;
    logic                    rd_issue;
    logic                    chk_active;
    logic [TIME_W-1:0]       cur_rem;
    logic [TIME_W-1:0]       cur_per;
    logic [TIME_W-1:0]       elapsed_ext;
    logic                    cur_fired;
    logic [TIME_W-1:0]       new_rem;
    logic                    ins_en;
    logic                    pop_en;
    logic                    resp_load;
    logic                    evt_take;

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign evt_take  = out_valid_reg && evt.ready;

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign cancel_hit = (int'(cmd.slot) < NUM_TIMERS);
    assign add_rem    = (cmd.period_ms > cmd.initial_ms) ? cmd.period_ms : cmd.initial_ms;

    // Walk: issue a read per cycle, process the returned entry the cycle after.
    assign rd_issue    = (state_reg == ST_WALK) && (idx_reg != CNT_W'(NUM_TIMERS));
    assign ram_raddr   = idx_reg[SLOT_W-1:0];
    assign cur_rem     = ram_rdata[TIME_W-1:0];
    assign cur_per     = ram_rdata[ENTRY_W-1:TIME_W];
    assign elapsed_ext = TIME_W'(elapsed_reg);
    assign cur_fired   = (cur_rem <= elapsed_ext);
    assign new_rem     = cur_fired ? cur_per : (cur_rem - elapsed_ext);
    assign chk_active  = chk_valid_reg && active_reg[chk_idx_reg];
    assign ins_en      = chk_active && cur_fired;

    // RAM write: add installs a new entry, walk writes back the updated remaining time.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = {cur_per, new_rem};
        if (cmd_acc && (cmd.action == ptt_pkg::ACT_ADD) && free_found)
        begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = {cmd.period_ms, add_rem};
        end
        else if (chk_active)
        begin
            ram_we = 1'b1;
        end
    end

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_TIMERS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pop the queue head into the output register once the walk is done.
    assign pop_en    = (state_reg == ST_POP) && q_valid_reg[0] && (!out_valid_reg || evt.ready);
    assign resp_load = (state_reg == ST_RESP) && (!out_valid_reg || evt.ready);

    // Sorted insert: a new entry goes in front of the first cell with a strictly larger
    // key, so equal keys keep ascending slot order (slots are walked low to high).
    generate
        for (genvar i = 0; i < NUM_TIMERS; i++)
        begin : g_cell
            logic              prev_gt;
            logic              prev_valid;
            logic [TIME_W-1:0] prev_key;
            logic [SLOT_W-1:0] prev_slot;
            logic              up_valid;
            logic [TIME_W-1:0] up_key;
            logic [SLOT_W-1:0] up_slot;
            logic              place;

            assign q_gt[i] = q_valid_reg[i] && (q_key_reg[i] > cur_rem);

            if (i == 0)
            begin : g_first
                assign prev_gt    = 1'b0;
                assign prev_valid = 1'b1;
                assign prev_key   = cur_rem;
                assign prev_slot  = chk_idx_reg;
            end
            else
            begin : g_rest
                assign prev_gt    = q_gt[i-1];
                assign prev_valid = q_valid_reg[i-1];
                assign prev_key   = q_key_reg[i-1];
                assign prev_slot  = q_slot_reg[i-1];
            end

            if (i == NUM_TIMERS - 1)
            begin : g_top
                assign up_valid = 1'b0;
                assign up_key   = q_key_reg[i];
                assign up_slot  = q_slot_reg[i];
            end
            else
            begin : g_mid
                assign up_valid = q_valid_reg[i+1];
                assign up_key   = q_key_reg[i+1];
                assign up_slot  = q_slot_reg[i+1];
            end

            assign place = q_gt[i] || (!q_valid_reg[i] && prev_valid);

            always_comb
            begin
                q_valid_next[i] = q_valid_reg[i];
                q_key_next[i]   = q_key_reg[i];
                q_slot_next[i]  = q_slot_reg[i];
                if (ins_en && place)
                begin
                    q_valid_next[i] = 1'b1;
                    q_key_next[i]   = prev_gt ? prev_key  : cur_rem;
                    q_slot_next[i]  = prev_gt ? prev_slot : chk_idx_reg;
                end
                else if (pop_en)
                begin
                    q_valid_next[i] = up_valid;
                    q_key_next[i]   = up_key;
                    q_slot_next[i]  = up_slot;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        q_key_reg  <= q_key_next;
        q_slot_reg <= q_slot_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.action == ptt_pkg::ACT_TICK)
                    begin
                        state_next = ST_WALK;
                    end
                    else if ((cmd.action == ptt_pkg::ACT_ADD) ||
                             (cmd.action == ptt_pkg::ACT_CANCEL))
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_WALK:
            begin
                if (!rd_issue)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!q_valid_reg[0])
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (resp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            q_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_valid_reg   <= q_valid_next;
            chk_valid_reg <= rd_issue;

            if (cmd_acc)
            begin
                idx_reg <= '0;
            end
            else if (rd_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (cmd_acc && (cmd.action == ptt_pkg::ACT_ADD) && free_found)
            begin
                active_reg[free_idx] <= 1'b1;
            end
            else if (cmd_acc && (cmd.action == ptt_pkg::ACT_CANCEL) && cancel_hit)
            begin
                active_reg[SLOT_W'(cmd.slot)] <= 1'b0;
            end

            if (pop_en || resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= ram_raddr;

        if (cmd_acc)
        begin
            elapsed_reg <= cmd.elapsed_ms;
            if (cmd.action == ptt_pkg::ACT_ADD)
            begin
                pend_kind_reg <= free_found ? ptt_pkg::KIND_ADDED : ptt_pkg::KIND_FULL;
                pend_slot_reg <= free_found ? SF_W'(free_idx) : '0;
            end
            else
            begin
                pend_kind_reg <= ptt_pkg::KIND_CANCELLED;
                pend_slot_reg <= cmd.slot;
            end
        end

        if (pop_en)
        begin
            out_kind_reg <= ptt_pkg::KIND_FIRED;
            out_slot_reg <= SF_W'(q_slot_reg[0]);
            out_last_reg <= ((q_valid_reg >> 1) == '0);
        end
        else if (resp_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.kind       = out_kind_reg;
    assign evt.timer_slot = out_slot_reg;
    assign evt.last       = out_last_reg;

`ifndef SYNTHESIS
    // Queue cells fill from the bottom with no holes.
    a_queue_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((q_valid_reg & (q_valid_reg + 1'b1)) == '0))
        else $error("fired queue has a hole");

    // Between commands the fired queue is empty.
    a_queue_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (q_valid_reg == '0))
        else $error("fired queue not drained");

    // Walk data only arrives while walking.
    a_chk_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_WALK))
        else $error("RAM data returned outside the walk");

    // A tick word starts a walk from slot zero.
    a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && (cmd.action == ptt_pkg::ACT_TICK)) |=>
            ((state_reg == ST_WALK) && (idx_reg == '0)))
        else $error("tick did not start a walk");

    // Queue inserts and pops never overlap.
    a_no_ins_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ins_en && pop_en))
        else $error("insert and pop in the same cycle");
`endif

endmodule

`default_nettype wire
